FILE: hw/rtl/sync_length_frame_receiver_assert.svh
// Assertion macros for the sync/length frame receiver.
// Used by the top level; needs a clock and an active-high reset in scope.
`ifndef SYNC_LENGTH_FRAME_RECEIVER_ASSERT_SVH
`define SYNC_LENGTH_FRAME_RECEIVER_ASSERT_SVH

// Same-cycle implication.
`define SLFR_ASSERT_SAME(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SLFR_ASSERT_NEXT(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/slfr_pkg.sv
// Shared types and constants for the sync/length frame receiver.
// No dependencies.
package slfr_pkg;

  typedef enum logic [1:0] {
    STAT_FLOW_OK   = 2'd0,
    STAT_OTHER_OK  = 2'd1,
    STAT_CSUM_FAIL = 2'd2,
    STAT_BAD_LEN   = 2'd3
  } status_t;

  localparam logic [7:0] SYNC_RESET      = 8'd153;
  localparam logic [7:0] TYPE_FLOW       = 8'd1;
  localparam logic [7:0] MIN_LENGTH      = 8'd4;
  localparam logic [7:0] MIN_FLOW_LENGTH = 8'd26;
  localparam logic [7:0] TYPE_POS        = 8'd3;
  localparam logic [7:0] STORE_FIRST     = 8'd4;
  localparam int         STORE_DEPTH     = 20;
  localparam logic [7:0] STORE_END       = 8'd24;
  localparam int         STORE_AW        = $clog2(STORE_DEPTH);
  localparam logic [15:0] FAIL_MAX       = 16'hFFFF;

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    status_t     status;
    logic [7:0]  msg_type;
    logic [31:0] vy_bits;
    logic [31:0] vx_bits;
    logic [31:0] rate_p_bits;
    logic [31:0] rate_q_bits;
    logic [31:0] rate_r_bits;
    logic [15:0] fail_count;
  } result_t;

  // queue head as seen by the back end
  typedef struct packed {
    logic    avail;
    result_t head;
  } q_head_t;

endpackage

FILE: hw/rtl/slfr_front.sv
// Front end: sync hunt, length capture, Fletcher sums and frame classification.
// Depends on slfr_pkg.
module slfr_front (
  input  logic                clk,
  input  logic                rst,
  input  logic [7:0]          sync_value,
  input  logic                in_take,
  input  logic [7:0]          rx_byte,
  output logic                res_valid,
  output slfr_pkg::result_t   res
);

  logic [7:0]  pos, pos_next;
  logic [7:0]  len, len_next;
  logic [7:0]  sum_a, sum_a_next;
  logic [7:0]  sum_b, sum_b_next;
  logic [7:0]  exp_a, exp_a_next;
  logic [15:0] fail_cnt, fail_cnt_next;
  logic [7:0]  type_byte;
  logic [7:0]  store [slfr_pkg::STORE_DEPTH];

  logic [7:0]  type_now;
  logic        is_end;
  logic        is_exp;
  logic [7:0]  sum_a_acc;

  assign type_now  = (pos == slfr_pkg::TYPE_POS) ? rx_byte : type_byte;
  assign is_end    = ({1'b0, pos} + 9'd1) == {1'b0, len};
  assign is_exp    = ({1'b0, pos} + 9'd2) == {1'b0, len};
  assign sum_a_acc = sum_a + rx_byte;

  always_comb begin
    pos_next      = pos;
    len_next      = len;
    sum_a_next    = sum_a;
    sum_b_next    = sum_b;
    exp_a_next    = exp_a;
    fail_cnt_next = fail_cnt;
    res_valid     = 1'b0;
    res           = '0;
    res.status    = slfr_pkg::STAT_BAD_LEN;
    if (pos == 8'd0) begin
      if (rx_byte == sync_value) begin
        pos_next = 8'd1;
      end
    end else if (pos == 8'd1) begin
      len_next = rx_byte;
      if (rx_byte < slfr_pkg::MIN_LENGTH) begin
        pos_next  = 8'd0;
        res_valid = 1'b1;
      end else begin
        sum_a_next = rx_byte;
        sum_b_next = rx_byte;
        pos_next   = 8'd2;
      end
    end else if (is_end) begin
      pos_next     = 8'd0;
      res_valid    = 1'b1;
      res.msg_type = type_now;
      if (type_now == slfr_pkg::TYPE_FLOW && len < slfr_pkg::MIN_FLOW_LENGTH) begin
        res.status = slfr_pkg::STAT_BAD_LEN;
      end else if (exp_a == sum_a && rx_byte == sum_b) begin
        if (type_now == slfr_pkg::TYPE_FLOW) begin
          res.status      = slfr_pkg::STAT_FLOW_OK;
          res.vy_bits     = {store[3], store[2], store[1], store[0]};
          res.vx_bits     = {~store[7][7], store[7][6:0], store[6], store[5], store[4]};
          res.rate_p_bits = {store[11], store[10], store[9], store[8]};
          res.rate_q_bits = {store[15], store[14], store[13], store[12]};
          res.rate_r_bits = {store[19], store[18], store[17], store[16]};
        end else begin
          res.status = slfr_pkg::STAT_OTHER_OK;
        end
      end else begin
        res.status = slfr_pkg::STAT_CSUM_FAIL;
        if (fail_cnt != slfr_pkg::FAIL_MAX) begin
          fail_cnt_next = fail_cnt + 16'd1;
        end
      end
    end else begin
      if (is_exp) begin
        exp_a_next = rx_byte;
      end else begin
        sum_a_next = sum_a_acc;
        sum_b_next = sum_b + sum_a_acc;
      end
      pos_next = pos + 8'd1;
    end
    res.fail_count = fail_cnt_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos      <= '0;
      len      <= '0;
      sum_a    <= '0;
      sum_b    <= '0;
      exp_a    <= '0;
      fail_cnt <= '0;
    end else if (in_take) begin
      pos      <= pos_next;
      len      <= len_next;
      sum_a    <= sum_a_next;
      sum_b    <= sum_b_next;
      exp_a    <= exp_a_next;
      fail_cnt <= fail_cnt_next;
    end
  end

  // payload bytes: only the message type and bytes 4..23 are ever read
  always_ff @(posedge clk) begin
    if (in_take) begin
      if (pos == slfr_pkg::TYPE_POS) begin
        type_byte <= rx_byte;
      end
      if (pos >= slfr_pkg::STORE_FIRST && pos < slfr_pkg::STORE_END) begin
        store[slfr_pkg::STORE_AW'(pos - slfr_pkg::STORE_FIRST)] <= rx_byte;
      end
    end
  end

endmodule

FILE: hw/rtl/slfr_queue.sv
// Short result queue between front and back end, first word fall through.
// Depends on slfr_pkg.
module slfr_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr_en,
  input  slfr_pkg::result_t   wr_data,
  input  logic                rd_en,
  output logic                full,
  output slfr_pkg::q_head_t   q_head
);

  slfr_pkg::result_t entries [slfr_pkg::QUEUE_DEPTH];
  logic [slfr_pkg::QUEUE_AW-1:0] wr_ptr, rd_ptr;
  logic [slfr_pkg::QUEUE_CW-1:0] count;

  localparam logic [slfr_pkg::QUEUE_CW-1:0] DEPTH_C = slfr_pkg::QUEUE_CW'(slfr_pkg::QUEUE_DEPTH);
  localparam logic [slfr_pkg::QUEUE_AW-1:0] LAST_C  =
    slfr_pkg::QUEUE_AW'(slfr_pkg::QUEUE_DEPTH - 1);
  localparam logic [slfr_pkg::QUEUE_AW-1:0] PTR_ONE = slfr_pkg::QUEUE_AW'(1);
  localparam logic [slfr_pkg::QUEUE_CW-1:0] CNT_ONE = slfr_pkg::QUEUE_CW'(1);

  assign full         = (count == DEPTH_C);
  assign q_head.avail = (count != '0);
  assign q_head.head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == LAST_C) ? '0 : wr_ptr + PTR_ONE;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == LAST_C) ? '0 : rd_ptr + PTR_ONE;
      end
      if (wr_en && !rd_en) begin
        count <= count + CNT_ONE;
      end else if (rd_en && !wr_en) begin
        count <= count - CNT_ONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entries[wr_ptr] <= wr_data;
    end
  end

endmodule

FILE: hw/rtl/slfr_back.sv
// Back end: output register that presents the oldest result to the consumer.
// Depends on slfr_pkg.
module slfr_back (
  input  logic                clk,
  input  logic                rst,
  input  slfr_pkg::q_head_t   q_head,
  output logic                q_rd,
  input  logic                pop,
  output logic                empty,
  output slfr_pkg::result_t   out_res
);

  logic out_valid;

  assign empty = !out_valid;
  assign q_rd  = q_head.avail && (!out_valid || pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_rd) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_rd) begin
      out_res <= q_head.head;
    end
  end

endmodule

FILE: hw/rtl/sync_length_frame_receiver.sv
// Sync/length framed serial receiver with Fletcher-style 8-bit checksum.
// Throughput: one byte per cycle while the result queue is not full; the front end
// updates position and sums for each byte taken. A result passes through the result
//   queue and then the output register before it reaches the output ports.
// Reset (rst, synchronous): hunting for sync, sums and failure count zero, sync byte 153.
// Depends on slfr_pkg, slfr_front, slfr_queue, slfr_back and the assertion header.
`include "sync_length_frame_receiver_assert.svh"

module sync_length_frame_receiver (
  input  logic        clk,
  input  logic        rst,
  // configuration: sync byte value
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,
  // byte input, queue style
  input  logic        push,
  output logic        full,
  input  logic [7:0]  rx_byte,
  // result output, queue style
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  status,
  output logic [7:0]  msg_type,
  output logic [31:0] vy_bits,
  output logic [31:0] vx_bits,
  output logic [31:0] rate_p_bits,
  output logic [31:0] rate_q_bits,
  output logic [31:0] rate_r_bits,
  output logic [15:0] fail_count
);

  logic              [7:0] sync_value;
  logic                    in_take;
  logic                    res_valid;
  slfr_pkg::result_t       front_res;
  slfr_pkg::q_head_t       q_head;
  logic                    q_rd;
  slfr_pkg::result_t       out_res;

  // Sync byte register; the user must write it only while the block is idle (not enforced).
  always_ff @(posedge clk) begin
    if (rst) begin
      sync_value <= slfr_pkg::SYNC_RESET;
    end else if (cfg_wr_en) begin
      sync_value <= cfg_wr_data;
    end
  end

  // An input transaction completes whenever the queue has room. The front end
  // makes at most one result per byte and writes it straight into the queue.
  assign in_take = push && !full;

  slfr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .sync_value (sync_value),
    .in_take    (in_take),
    .rx_byte    (rx_byte),
    .res_valid  (res_valid),
    .res        (front_res)
  );

  // Queue decouples the parser from the consumer; full backpressures input.
  slfr_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (in_take && res_valid),
    .wr_data (front_res),
    .rd_en   (q_rd),
    .full    (full),
    .q_head  (q_head)
  );

  // Output register; refills in the same cycle it is popped when the queue holds a result.
  slfr_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_head  (q_head),
    .q_rd    (q_rd),
    .pop     (pop),
    .empty   (empty),
    .out_res (out_res)
  );

  assign status      = out_res.status;
  assign msg_type    = out_res.msg_type;
  assign vy_bits     = out_res.vy_bits;
  assign vx_bits     = out_res.vx_bits;
  assign rate_p_bits = out_res.rate_p_bits;
  assign rate_q_bits = out_res.rate_q_bits;
  assign rate_r_bits = out_res.rate_r_bits;
  assign fail_count  = out_res.fail_count;

  // A good status-0 result is always a type 1 frame.
  `SLFR_ASSERT_SAME(a_flow_type, clk, rst,
    !empty && status == slfr_pkg::STAT_FLOW_OK, msg_type == slfr_pkg::TYPE_FLOW,
    "flow result with wrong message type")

  // Words are only carried by good type 1 frames.
  `SLFR_ASSERT_SAME(a_words_zero, clk, rst,
    !empty && status != slfr_pkg::STAT_FLOW_OK,
    vy_bits == '0 && vx_bits == '0 && rate_p_bits == '0 && rate_q_bits == '0
      && rate_r_bits == '0,
    "payload words set on a non-flow result")

  // Bad length comes from a short length byte (type 0) or a short type 1 frame.
  `SLFR_ASSERT_SAME(a_bad_len_type, clk, rst,
    !empty && status == slfr_pkg::STAT_BAD_LEN,
    msg_type == 8'd0 || msg_type == slfr_pkg::TYPE_FLOW,
    "bad length result with unexpected message type")

  // Results leave in order, so the failure count never goes down.
  `SLFR_ASSERT_NEXT(a_fail_mono, clk, rst,
    pop && !empty, empty || fail_count >= $past(fail_count),
    "failure count decreased between results")

endmodule
